// File: rtl/tpts_pkg.sv
// Shared types, codes and sizes for the task scheduler.
// No dependencies; imported by the top level and tpts_order.
`timescale 1ns / 1ps
`default_nettype none

package tpts_pkg;

  localparam int MAX_TASKS   = 32;
  localparam int WQ_AW       = 5;   // waiting queue index
  localparam int TID_W       = 6;   // task id, 1..MAX_TASKS
  localparam int MAX_THREADS = 8;
  localparam int THR_W       = 3;
  localparam int RQ_CW       = 4;   // running / free counts, 0..MAX_THREADS
  localparam int WQ_CW       = 6;   // waiting count, 0..MAX_TASKS

  localparam logic [4:0] MAX_ADD = 5'd16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_QTASK = 2'd2;
  localparam logic [1:0] OP_QTHR  = 2'd3;

  localparam logic [3:0] ST_CREATED  = 4'd0;
  localparam logic [3:0] ST_FULL     = 4'd1;
  localparam logic [3:0] ST_RUN_DONE = 4'd2;
  localparam logic [3:0] ST_RUNNING  = 4'd3;
  localparam logic [3:0] ST_WAITING  = 4'd4;
  localparam logic [3:0] ST_FINISHED = 4'd5;
  localparam logic [3:0] ST_NOTFOUND = 4'd6;
  localparam logic [3:0] ST_BUSY     = 4'd7;
  localparam logic [3:0] ST_IDLE     = 4'd8;

  typedef struct packed {
    logic [TID_W-1:0] id;
    logic [7:0]       prio;
    logic [15:0]      exec;
  } task_key_t;

  typedef struct packed {
    task_key_t        key;
    logic [15:0]      rem;
    logic [THR_W-1:0] thr;
  } run_rec_t;

  typedef struct packed {
    logic [TID_W-1:0] id;
    logic [15:0]      exec;
  } fin_rec_t;

endpackage

`default_nettype wire

// File: rtl/thread_pool_task_scheduler_unit.sv
// Priority task scheduler with a thread pool: top level.
// Depends on tpts_pkg, tpts_order and tpts_ram.
//
// Usage
//  Input channel (in_valid / in_stall): one command item per handshake:
//  add, run, task query, thread query. in_stall is high while a command
//  is in work; one command is handled at a time.
//  Result channel (out_valid / out_stall): add gives one item per task
//  created, then a table-full item if the table fills; others give one item.
//  out_last marks the final item of a command. A one-deep output register
//  holds a result while the receiver stalls; the sequencer only waits when
//  it has a further result and that register is still occupied.
//  Config port (cfg_we): thread_count (index 0), quantum (index 1); write
//  only while idle.
//  Command steps; the queues are walked an entry per cycle, and the add
//  and run walks share one order comparator:
//   add: per task, a scan for the lowest free id, a waiting-queue walk,
//        the insert and the result; a full table ends it after the scan.
//   run: floor(duration/quantum)+1 steps; each step moves waiting tasks
//        onto free threads (a walk of the running queue and an insert per
//        task moved), then charges the step to every running task.
//   task query: walks the running queue, the waiting queue, then the
//        finished log (log RAM has one registered read).
//   thread query: walks the running queue.
//  Reset (synchronous, rst_n low): queues and log empty, all ids free,
//  4 threads with thread 0 on top of the free stack, quantum 10, time 0.
`timescale 1ns / 1ps
`default_nettype none

module thread_pool_task_scheduler_unit
  import tpts_pkg::*;
#(
  parameter int FINISHED_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  // command channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_operation,
  input  wire  [4:0]  in_task_count,
  input  wire  [7:0]  in_priority_req,
  input  wire  [15:0] in_exec_time,
  input  wire  [15:0] in_duration,
  input  wire  [5:0]  in_query_id,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  out_status,
  output logic [5:0]  out_task_id,
  output logic [2:0]  out_thread_id,
  output logic [31:0] out_time_value,
  output logic        out_last,
  // configuration
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [15:0] cfg_wdata
);

  localparam int FA_W = $clog2(FINISHED_DEPTH);
  localparam int FC_W = $clog2(FINISHED_DEPTH + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ADD_ID   = 4'd1;
  localparam logic [3:0] S_ADD_POS  = 4'd2;
  localparam logic [3:0] S_ADD_INS  = 4'd3;
  localparam logic [3:0] S_EMIT     = 4'd4;
  localparam logic [3:0] S_RUN_MOVE = 4'd5;
  localparam logic [3:0] S_RUN_POS  = 4'd6;
  localparam logic [3:0] S_RUN_INS  = 4'd7;
  localparam logic [3:0] S_RUN_DEC  = 4'd8;
  localparam logic [3:0] S_QT_RUN   = 4'd9;
  localparam logic [3:0] S_QT_WAIT  = 4'd10;
  localparam logic [3:0] S_QT_FRD   = 4'd11;
  localparam logic [3:0] S_QT_FCMP  = 4'd12;
  localparam logic [3:0] S_QH       = 4'd13;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_THREADS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM = 1'b1;

  // ---------------- state ----------------
  logic [3:0]             state_r, state_nxt;
  task_key_t              wq_r [MAX_TASKS];
  task_key_t              wq_nxt [MAX_TASKS];
  logic [WQ_CW-1:0]       wcnt_r, wcnt_nxt;
  run_rec_t               rq_r [MAX_THREADS];
  run_rec_t               rq_nxt [MAX_THREADS];
  logic [RQ_CW-1:0]       rcnt_r, rcnt_nxt;
  logic [THR_W-1:0]       stk_r [MAX_THREADS];
  logic [THR_W-1:0]       stk_nxt [MAX_THREADS];
  logic [RQ_CW-1:0]       fcnt_r, fcnt_nxt;      // free threads
  logic [MAX_TASKS-1:0]   used_r, used_nxt;
  logic [31:0]            total_r, total_nxt;
  logic [3:0]             tcnt_r, tcnt_nxt;
  logic [15:0]            quant_r, quant_nxt;
  logic [FA_W-1:0]        head_r, head_nxt;
  logic [FA_W-1:0]        tail_r, tail_nxt;
  logic [FC_W-1:0]        lcnt_r, lcnt_nxt;      // finished log fill

  // command and walk registers
  logic [4:0]             tleft_r, tleft_nxt;    // tasks still to add
  logic [7:0]             prio_r, prio_nxt;
  logic [15:0]            exec_r, exec_nxt;
  logic [5:0]             qid_r, qid_nxt;
  logic [15:0]            left_r, left_nxt;      // run time still to go
  run_rec_t               t_r, t_nxt;            // task being placed
  logic [WQ_CW-1:0]       ws_r, ws_nxt;
  logic [RQ_CW-1:0]       rs_r, rs_nxt;
  logic [RQ_CW-1:0]       kept_r, kept_nxt;
  logic [15:0]            most_r, most_nxt;
  logic [FC_W-1:0]        fi_r, fi_nxt;
  logic [FA_W-1:0]        fa_r, fa_nxt;

  // pending result
  logic [3:0]             res_st_r, res_st_nxt;
  logic [5:0]             res_id_r, res_id_nxt;
  logic [2:0]             res_thr_r, res_thr_nxt;
  logic [31:0]            res_tv_r, res_tv_nxt;
  logic                   res_last_r, res_last_nxt;

  // output register
  logic                   ov_r, ov_nxt;
  logic [3:0]             o_st_r;
  logic [5:0]             o_id_r;
  logic [2:0]             o_thr_r;
  logic [31:0]            o_tv_r;
  logic                   o_last_r;
  logic                   out_ld;

  // shared compare unit and log RAM
  task_key_t              key_b;
  logic                   a_first;
  logic                   fin_we;
  fin_rec_t               fin_wdata;
  fin_rec_t               fin_rdata;

  logic [15:0]            q_eff;
  logic [15:0]            step;
  logic [31:0]            tot_sum;
  logic                   in_acc;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign q_eff    = (quant_r == 16'd0) ? 16'd1 : quant_r;
  assign step     = (left_r < q_eff) ? left_r : q_eff;
  assign tot_sum  = total_r + ((kept_r != '0) ? {16'd0, step} : {16'd0, most_r});
  assign out_ld   = (state_r == S_EMIT) && (!ov_r || !out_stall);

  assign key_b = (state_r == S_RUN_POS) ? rq_r[rs_r[THR_W-1:0]].key
                                        : wq_r[ws_r[WQ_AW-1:0]];

  tpts_order u_order (
    .a_key   (t_r.key),
    .b_key   (key_b),
    .a_first (a_first)
  );

  tpts_ram #(
    .WIDTH ($bits(fin_rec_t)),
    .DEPTH (FINISHED_DEPTH)
  ) u_fin_log (
    .clk   (clk),
    .we    (fin_we),
    .waddr (tail_r),
    .wdata (fin_wdata),
    .raddr (fa_r),
    .rdata (fin_rdata)
  );

  always_comb begin
    run_rec_t   e;
    logic [3:0] tc_v;
    e            = rq_r[rs_r[THR_W-1:0]];
    tc_v         = cfg_wdata[3:0];
    state_nxt    = state_r;
    wq_nxt       = wq_r;
    wcnt_nxt     = wcnt_r;
    rq_nxt       = rq_r;
    rcnt_nxt     = rcnt_r;
    stk_nxt      = stk_r;
    fcnt_nxt     = fcnt_r;
    used_nxt     = used_r;
    total_nxt    = total_r;
    tcnt_nxt     = tcnt_r;
    quant_nxt    = quant_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    lcnt_nxt     = lcnt_r;
    tleft_nxt    = tleft_r;
    prio_nxt     = prio_r;
    exec_nxt     = exec_r;
    qid_nxt      = qid_r;
    left_nxt     = left_r;
    t_nxt        = t_r;
    ws_nxt       = ws_r;
    rs_nxt       = rs_r;
    kept_nxt     = kept_r;
    most_nxt     = most_r;
    fi_nxt       = fi_r;
    fa_nxt       = fa_r;
    res_st_nxt   = res_st_r;
    res_id_nxt   = res_id_r;
    res_thr_nxt  = res_thr_r;
    res_tv_nxt   = res_tv_r;
    res_last_nxt = res_last_r;
    fin_we       = 1'b0;
    fin_wdata.id   = e.key.id;
    fin_wdata.exec = e.key.exec;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          prio_nxt = in_priority_req;
          exec_nxt = in_exec_time;
          qid_nxt  = in_query_id;
          left_nxt = in_duration;
          ws_nxt   = '0;
          rs_nxt   = '0;
          case (in_operation)
            OP_ADD: begin
              tleft_nxt = (in_task_count > MAX_ADD) ? MAX_ADD : in_task_count;
              if (in_task_count != 5'd0) begin
                state_nxt = S_ADD_ID;
              end
            end
            OP_RUN:   state_nxt = S_RUN_MOVE;
            OP_QTASK: state_nxt = S_QT_RUN;
            default: begin
              if (in_query_id >= {2'b00, tcnt_r}) begin
                res_st_nxt   = ST_NOTFOUND;
                res_id_nxt   = '0;
                res_thr_nxt  = in_query_id[2:0];
                res_tv_nxt   = '0;
                res_last_nxt = 1'b1;
                state_nxt    = S_EMIT;
              end else begin
                state_nxt = S_QH;
              end
            end
          endcase
        end
      end

      // lowest free id, one bit per cycle
      S_ADD_ID: begin
        if (ws_r == WQ_CW'(MAX_TASKS)) begin
          res_st_nxt   = ST_FULL;
          res_id_nxt   = '0;
          res_thr_nxt  = '0;
          res_tv_nxt   = '0;
          res_last_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end else if (!used_r[ws_r[WQ_AW-1:0]]) begin
          used_nxt[ws_r[WQ_AW-1:0]] = 1'b1;
          t_nxt.key.id   = ws_r + 1'b1;
          t_nxt.key.prio = prio_r;
          t_nxt.key.exec = exec_r;
          t_nxt.rem      = exec_r;
          t_nxt.thr      = '0;
          ws_nxt         = '0;
          state_nxt      = S_ADD_POS;
        end else begin
          ws_nxt = ws_r + 1'b1;
        end
      end

      S_ADD_POS: begin
        if (ws_r == wcnt_r || a_first) begin
          state_nxt = S_ADD_INS;
        end else begin
          ws_nxt = ws_r + 1'b1;
        end
      end

      S_ADD_INS: begin
        for (int j = 1; j < MAX_TASKS; j++) begin
          if (WQ_CW'(j) > ws_r && WQ_CW'(j) <= wcnt_r) begin
            wq_nxt[j] = wq_r[j-1];
          end
        end
        wq_nxt[ws_r[WQ_AW-1:0]] = t_r.key;
        wcnt_nxt     = wcnt_r + 1'b1;
        res_st_nxt   = ST_CREATED;
        res_id_nxt   = t_r.key.id;
        res_thr_nxt  = '0;
        res_tv_nxt   = {16'd0, t_r.key.exec};
        res_last_nxt = (tleft_r == 5'd1);
        tleft_nxt    = tleft_r - 1'b1;
        ws_nxt       = '0;
        state_nxt    = S_EMIT;
      end

      S_EMIT: begin
        if (out_ld) begin
          state_nxt = res_last_r ? S_IDLE : S_ADD_ID;
        end
      end

      // pair a free thread with the waiting head
      S_RUN_MOVE: begin
        if (fcnt_r != '0 && wcnt_r != '0) begin
          t_nxt.key = wq_r[0];
          t_nxt.rem = wq_r[0].exec;
          t_nxt.thr = stk_r[THR_W'(fcnt_r - 1'b1)];
          fcnt_nxt  = fcnt_r - 1'b1;
          for (int j = 0; j < MAX_TASKS - 1; j++) begin
            wq_nxt[j] = wq_r[j+1];
          end
          wcnt_nxt  = wcnt_r - 1'b1;
          rs_nxt    = '0;
          state_nxt = S_RUN_POS;
        end else begin
          rs_nxt    = '0;
          kept_nxt  = '0;
          most_nxt  = '0;
          state_nxt = S_RUN_DEC;
        end
      end

      S_RUN_POS: begin
        if (rs_r == rcnt_r || a_first) begin
          state_nxt = S_RUN_INS;
        end else begin
          rs_nxt = rs_r + 1'b1;
        end
      end

      S_RUN_INS: begin
        for (int j = 1; j < MAX_THREADS; j++) begin
          if (RQ_CW'(j) > rs_r && RQ_CW'(j) <= rcnt_r) begin
            rq_nxt[j] = rq_r[j-1];
          end
        end
        rq_nxt[rs_r[THR_W-1:0]] = t_r;
        rcnt_nxt  = rcnt_r + 1'b1;
        state_nxt = S_RUN_MOVE;
      end

      // one running task per cycle: charge the step, compact in place
      S_RUN_DEC: begin
        if (rs_r < rcnt_r) begin
          if (e.rem > step) begin
            e.rem = e.rem - step;
            rq_nxt[kept_r[THR_W-1:0]] = e;
            kept_nxt = kept_r + 1'b1;
          end else begin
            if (e.rem > most_r) begin
              most_nxt = e.rem;
            end
            if (fcnt_r < RQ_CW'(MAX_THREADS)) begin
              stk_nxt[fcnt_r[THR_W-1:0]] = e.thr;
              fcnt_nxt = fcnt_r + 1'b1;
            end
            used_nxt[WQ_AW'(e.key.id - 1'b1)] = 1'b0;
            fin_we = 1'b1;
            if (lcnt_r == FC_W'(FINISHED_DEPTH)) begin
              head_nxt = (head_r == FA_W'(FINISHED_DEPTH - 1)) ? '0 : head_r + 1'b1;
            end else begin
              lcnt_nxt = lcnt_r + 1'b1;
            end
            tail_nxt = (tail_r == FA_W'(FINISHED_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          end
          rs_nxt = rs_r + 1'b1;
        end else begin
          rcnt_nxt  = kept_r;
          total_nxt = tot_sum;
          if (left_r < q_eff) begin
            res_st_nxt   = ST_RUN_DONE;
            res_id_nxt   = '0;
            res_thr_nxt  = '0;
            res_tv_nxt   = tot_sum;
            res_last_nxt = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            left_nxt  = left_r - q_eff;
            state_nxt = S_RUN_MOVE;
          end
        end
      end

      S_QT_RUN: begin
        if (rs_r < rcnt_r) begin
          if (e.key.id == qid_r) begin
            res_st_nxt   = ST_RUNNING;
            res_id_nxt   = qid_r;
            res_thr_nxt  = e.thr;
            res_tv_nxt   = {16'd0, e.rem};
            res_last_nxt = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            rs_nxt = rs_r + 1'b1;
          end
        end else begin
          ws_nxt    = '0;
          state_nxt = S_QT_WAIT;
        end
      end

      S_QT_WAIT: begin
        if (ws_r < wcnt_r) begin
          if (key_b.id == qid_r) begin
            res_st_nxt   = ST_WAITING;
            res_id_nxt   = qid_r;
            res_thr_nxt  = '0;
            res_tv_nxt   = {16'd0, key_b.exec};
            res_last_nxt = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            ws_nxt = ws_r + 1'b1;
          end
        end else begin
          fi_nxt    = '0;
          fa_nxt    = head_r;
          state_nxt = S_QT_FRD;
        end
      end

      // log read is registered: address this cycle, compare the next
      S_QT_FRD: begin
        if (fi_r < lcnt_r) begin
          state_nxt = S_QT_FCMP;
        end else begin
          res_st_nxt   = ST_NOTFOUND;
          res_id_nxt   = qid_r;
          res_thr_nxt  = '0;
          res_tv_nxt   = '0;
          res_last_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end
      end

      S_QT_FCMP: begin
        if (fin_rdata.id == qid_r) begin
          res_st_nxt   = ST_FINISHED;
          res_id_nxt   = qid_r;
          res_thr_nxt  = '0;
          res_tv_nxt   = {16'd0, fin_rdata.exec};
          res_last_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          fi_nxt    = fi_r + 1'b1;
          fa_nxt    = (fa_r == FA_W'(FINISHED_DEPTH - 1)) ? '0 : fa_r + 1'b1;
          state_nxt = S_QT_FRD;
        end
      end

      S_QH: begin
        if (rs_r < rcnt_r) begin
          if (e.thr == qid_r[2:0]) begin
            res_st_nxt   = ST_BUSY;
            res_id_nxt   = e.key.id;
            res_thr_nxt  = qid_r[2:0];
            res_tv_nxt   = {16'd0, e.rem};
            res_last_nxt = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            rs_nxt = rs_r + 1'b1;
          end
        end else begin
          res_st_nxt   = ST_IDLE;
          res_id_nxt   = '0;
          res_thr_nxt  = qid_r[2:0];
          res_tv_nxt   = '0;
          res_last_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // config writes are to be made only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        REG_THREADS: begin
          if (tc_v == 4'd0) begin
            tc_v = 4'd1;
          end else if (tc_v > 4'(MAX_THREADS)) begin
            tc_v = 4'(MAX_THREADS);
          end
          tcnt_nxt = tc_v;
          if (rcnt_r == '0) begin
            for (int j = 0; j < MAX_THREADS; j++) begin
              if (4'(j) < tc_v) begin
                stk_nxt[j] = THR_W'(tc_v - 4'd1 - 4'(j));
              end
            end
            fcnt_nxt = tc_v;
          end
        end
        REG_QUANTUM: quant_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ov_nxt = out_ld ? 1'b1 : (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wcnt_r  <= '0;
      rcnt_r  <= '0;
      used_r  <= '0;
      total_r <= '0;
      tcnt_r  <= 4'd4;
      quant_r <= 16'd10;
      fcnt_r  <= 4'd4;
      for (int j = 0; j < MAX_THREADS; j++) begin
        stk_r[j] <= (j < 4) ? THR_W'(3 - j) : '0;
      end
      head_r  <= '0;
      tail_r  <= '0;
      lcnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wcnt_r  <= wcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      used_r  <= used_nxt;
      total_r <= total_nxt;
      tcnt_r  <= tcnt_nxt;
      quant_r <= quant_nxt;
      fcnt_r  <= fcnt_nxt;
      stk_r   <= stk_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      lcnt_r  <= lcnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wq_r       <= wq_nxt;
    rq_r       <= rq_nxt;
    tleft_r    <= tleft_nxt;
    prio_r     <= prio_nxt;
    exec_r     <= exec_nxt;
    qid_r      <= qid_nxt;
    left_r     <= left_nxt;
    t_r        <= t_nxt;
    ws_r       <= ws_nxt;
    rs_r       <= rs_nxt;
    kept_r     <= kept_nxt;
    most_r     <= most_nxt;
    fi_r       <= fi_nxt;
    fa_r       <= fa_nxt;
    res_st_r   <= res_st_nxt;
    res_id_r   <= res_id_nxt;
    res_thr_r  <= res_thr_nxt;
    res_tv_r   <= res_tv_nxt;
    res_last_r <= res_last_nxt;
    if (out_ld) begin
      o_st_r   <= res_st_r;
      o_id_r   <= res_id_r;
      o_thr_r  <= res_thr_r;
      o_tv_r   <= res_tv_r;
      o_last_r <= res_last_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_status     = o_st_r;
  assign out_task_id    = o_id_r;
  assign out_thread_id  = o_thr_r;
  assign out_time_value = o_tv_r;
  assign out_last       = o_last_r;

`ifndef SYNTHESIS
  // at rest threads are either free or running, never more than the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (({1'b0, fcnt_r} + {1'b0, rcnt_r}) <= 5'(MAX_THREADS)))
    else $error("free plus running threads exceed the pool");

  // at rest every id in use belongs to a waiting or running task
  a_id_books: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(used_r) == (32'(wcnt_r) + 32'(rcnt_r))))
    else $error("id bitmap disagrees with queue counts");

  // a non-add command always starts work
  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation != OP_ADD) |=> (state_r != S_IDLE))
    else $error("command accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

// File: rtl/tpts_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tpts_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/tpts_order.sv
// Queue ordering compare: priority descending, exec time ascending, id ascending.
// Depends on tpts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpts_order
  import tpts_pkg::*;
(
  input  task_key_t a_key,
  input  task_key_t b_key,
  output logic      a_first
);

  always_comb begin
    if (a_key.prio != b_key.prio) begin
      a_first = a_key.prio > b_key.prio;
    end else if (a_key.exec != b_key.exec) begin
      a_first = a_key.exec < b_key.exec;
    end else begin
      a_first = a_key.id < b_key.id;
    end
  end

endmodule

`default_nettype wire
